### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sliding window averager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SWA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/swa_pkg.sv
// Shared types and constants of the sliding window averager.
package swa_pkg;

    // Configuration bus geometry and register map.
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int CFG_BYTE_W  = 8;
    localparam logic REG_WINDOW_SIZE = 1'b0;   // selected by paddr[2]

    // Divider handshake, driven by the control logic.
    typedef struct packed {
        logic start;
        logic take;
    } t_div_ctl;

    // Divider status back to the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

### hdl/swa_ring.sv
// Sample ring memory: one write port, one read port, registered read data.
module swa_ring #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/swa_div.sv
// Signed by unsigned restoring divider, one quotient bit per cycle.
module swa_div import swa_pkg::*; #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 7,
    parameter int Q_W   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_ctl                i_ctl,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output t_div_sts                o_sts,
    output logic [Q_W-1:0]          o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;

    logic [DVS_W:0]    n_trial;
    logic              n_fits;
    logic [DVD_W-1:0]  n_mag;
    logic [DVD_W-1:0]  n_quo_signed;

    // Trial subtract of the shifted remainder
    always_comb begin
        n_trial = {r_rem, r_quo[DVD_W-1]};
        n_fits  = (n_trial >= {1'b0, r_div});
        n_mag   = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
    end

    // Iterate: shift the dividend out, the quotient bits in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_neg  <= i_dividend[DVD_W-1];
            r_quo  <= n_mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= STEP_W'(DVD_W);
        end else if (r_busy) begin
            r_quo  <= {r_quo[DVD_W-2:0], n_fits};
            r_rem  <= n_fits ? DVS_W'(n_trial - {1'b0, r_div}) : n_trial[DVS_W-1:0];
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ctl.take) begin
            r_done <= 1'b0;
        end
    end

    // Restore the sign; the average always fits the sample width
    assign n_quo_signed = r_neg ? DVD_W'(-r_quo) : r_quo;
    assign o_quotient   = n_quo_signed[Q_W-1:0];
    assign o_sts.busy   = r_busy;
    assign o_sts.done   = r_done;

endmodule

### hdl/sliding_window_average_core.sv
// Moving average over a ring of recent samples, top level.
//
//  channel   | dir | handshake                         | payload
//  ----------+-----+-----------------------------------+---------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready     | tdata: sample
//  m_axis    | out | m_axis_tvalid / m_axis_tready     | tdata: average, tuser: window_full
//  apb       | in  | psel, penable, pwrite, pready = 1 | window_size at address 0
//
//  Only one item is in flight: the next one is taken once the bit-serial divider
//  has finished and its result has been loaded into the output register.
//  Ring read is issued on acceptance, read-modify-write follows in the next cycle.
//  A finished result waits in the output register; the next item is taken meanwhile.
//  Reset is synchronous; the ring itself is not cleared, its entries are used only
//  once the window is full. A window_size write restarts the filter.
module sliding_window_average_core import swa_pkg::*; #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    // average stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // [SAMPLE_BITS-1:0] average
    output logic [0:0]                    m_axis_tuser,  // [0] window_full
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    `include "assert_macros.svh"

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int WIN_RST = (8 > WINDOW_MAX) ? WINDOW_MAX : 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_window;
    logic [CNT_W-1:0]        r_count;
    logic [ADDR_W-1:0]       r_slot;
    logic signed [SUM_W-1:0] r_sum;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic                    r_full_pend;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_avg;
    logic                    r_full;

    logic                    n_accept;
    logic                    n_cfg_wr;
    logic [CFG_BYTE_W-1:0]   n_cfg_byte;
    logic [CNT_W-1:0]        n_cfg_window;
    logic                    n_win_full;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        n_slot_inc;
    logic [ADDR_W-1:0]       n_slot;
    logic                    n_out_load;
    logic [SAMPLE_BITS-1:0]  w_old;
    logic [SAMPLE_BITS-1:0]  w_quo;
    t_div_ctl                w_div_ctl;
    t_div_sts                w_div_sts;

    assign n_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Configuration decode: ignore a zero window, clamp to the ring depth
    assign pready       = 1'b1;
    assign n_cfg_byte   = pwdata[CFG_BYTE_W-1:0];
    assign n_cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE)
                          && (n_cfg_byte != '0);
    assign n_cfg_window = (n_cfg_byte > CFG_BYTE_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                                 : CNT_W'(n_cfg_byte);
    assign prdata       = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(r_window) : '0;

    // Sum update: drop the oldest sample once the window is full
    always_comb begin
        n_win_full = (r_count == r_window);
        n_sum      = r_sum + SUM_W'($signed(r_sample))
                     - (n_win_full ? SUM_W'($signed(w_old)) : SUM_W'(0));
        n_count    = n_win_full ? r_count : r_count + CNT_W'(1);
        n_slot_inc = CNT_W'(r_slot) + CNT_W'(1);
        n_slot     = (n_slot_inc >= r_window) ? '0 : n_slot_inc[ADDR_W-1:0];
    end

    assign w_div_ctl.start = (r_state == ST_READ);
    assign n_out_load      = (r_state == ST_DIV) && w_div_sts.done
                             && (!r_out_valid || m_axis_tready);
    assign w_div_ctl.take  = n_out_load;

    // Sample ring: read on acceptance, write back in the next cycle
    swa_ring #(
        .DEPTH  (WINDOW_MAX),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_READ),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (n_accept),
        .i_raddr (r_slot),
        .o_rdata (w_old)
    );

    swa_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .Q_W   (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_sts      (w_div_sts),
        .o_quotient (w_quo)
    );

    // Control state, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= CNT_W'(WIN_RST);
            r_count     <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_sum       <= n_sum;
                    r_count     <= n_count;
                    r_slot      <= n_slot;
                    r_full_pend <= (n_count == r_window);
                    r_state     <= ST_DIV;
                end
                ST_DIV: begin
                    if (n_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Hold the result until taken, refill from the divider
            if (n_out_load) begin
                r_out_valid <= 1'b1;
                r_avg       <= w_quo;
                r_full      <= r_full_pend;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Restart the filter on a window write
            if (n_cfg_wr) begin
                r_window <= n_cfg_window;
                r_count  <= '0;
                r_slot   <= '0;
                r_sum    <= '0;
            end
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = TDATA_W'(r_avg);
    assign m_axis_tuser[0] = r_full;

    `SWA_ASSERT_RST(a_count_in_window, i_clk, i_rst_n, (r_count <= r_window), "fill count exceeds window")
    `SWA_ASSERT_RST(a_slot_in_window, i_clk, i_rst_n, (CNT_W'(r_slot) < r_window), "write slot outside window")
    `SWA_ASSERT_RST(a_div_idle, i_clk, i_rst_n, (r_state == ST_IDLE) |-> !w_div_sts.busy, "divider busy while idle")
    `SWA_ASSERT_ALWAYS(a_accept_reads, i_clk, (i_rst_n && n_accept) |=> (r_state == ST_READ), "accepted item did not enter read")

endmodule

### verif/sliding_window_average_core_test.sv
// Self-checking stream test of the sliding window averager with APB window control.
`timescale 1ns / 100ps

module sliding_window_average_core_test;
    import swa_pkg::*;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int WINDOW_RESET  = 8;

    // Register indexes; byte address is index * 4
    localparam int REG_IDX_WINDOW   = 0;
    localparam int REG_IDX_UNMAPPED = 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t average;
        logic    full;
    } avg_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;   // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;        // [15:0] average
    logic [0:0]            m_axis_tuser;        // [0] window_full
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Moving-average predictor state
    longint      ring_copy [WINDOW_MAX];
    longint      window_sum;
    int          next_slot;
    int          held_count;
    int          window_len;
    avg_result_t pending_averages [$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int results_checked;
    int samples_sent;
    int window_writes;

    sliding_window_average_core #(
        .WINDOW_MAX (WINDOW_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Restart the filter as a window_size write does
    task automatic predict_window_write(input int index, input logic [APB_DATA_W-1:0] value);
        int w;
        if (index != REG_IDX_WINDOW) begin
            return;
        end
        w = int'(value[CFG_BYTE_W-1:0]);
        if (w == 0) begin
            return;
        end
        if (w > WINDOW_MAX) begin
            w = WINDOW_MAX;
        end
        window_len = w;
        window_sum = 0;
        next_slot  = 0;
        held_count = 0;
    endtask

    // Update the running sum for one accepted sample and queue its average
    task automatic predict_average(input sample_t s);
        int          slot;
        longint      quotient;
        avg_result_t r;
        slot = next_slot;
        if (slot >= window_len) begin
            slot = 0;
        end
        if (held_count < window_len) begin
            window_sum += s;
            held_count++;
        end else begin
            window_sum = window_sum - ring_copy[slot] + s;
        end
        ring_copy[slot] = s;
        slot++;
        if (slot >= window_len) begin
            slot = 0;
        end
        next_slot = slot;
        quotient  = window_sum / held_count;
        r.average = quotient[SAMPLE_BITS-1:0];
        r.full    = (held_count == window_len);
        pending_averages.push_back(r);
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_transfer(input logic wr, input int index,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(index * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input int index, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_transfer(1'b1, index, value, unused);
        predict_window_write(index, value);
        window_writes++;
    endtask

    task automatic check_window_reg();
        logic [APB_DATA_W-1:0] rd;
        apb_transfer(1'b0, REG_IDX_WINDOW, '0, rd);
        if (rd[CFG_BYTE_W-1:0] != CFG_BYTE_W'(window_len)) begin
            note_mismatch($sformatf("window_size read %0d, expected %0d",
                                    rd[CFG_BYTE_W-1:0], window_len));
        end
    endtask

    // Offer one item, with random idle cycles ahead of it, and hold until accepted
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(s);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_average(s);
        samples_sent++;
    endtask

    // Drop valid and let all outstanding averages drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return sample_t'(int'($urandom_range(64)) - 32);
            3: return sample_t'($urandom_range(32767));
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Reset value of the window, fill, wrap and saturated extremes
    task automatic test_default_window();
        check_window_reg();
        repeat (4) send_sample(16'sh7FFF);
        repeat (4) send_sample(16'sh8000);
        send_sample(-16'sd1);
        wait_idle();
    endtask

    // Division truncates toward zero for both signs
    task automatic test_truncation();
        write_reg(REG_IDX_WINDOW, 32'd3);
        send_sample(-16'sd5);
        send_sample(16'sd0);
        send_sample(16'sd7);
        send_sample(16'sd1);
        wait_idle();
    endtask

    // Zero window, zero low byte and an unmapped address leave the filter running
    task automatic test_ignored_writes();
        write_reg(REG_IDX_WINDOW, 32'd5);
        send_sample(16'sd100);
        send_sample(-16'sd3);
        wait_idle();
        write_reg(REG_IDX_WINDOW, 32'd0);
        check_window_reg();
        send_sample(16'sd1);
        wait_idle();
        write_reg(REG_IDX_WINDOW, 32'hFFFF_FF00);
        send_sample(16'sh7FFF);
        wait_idle();
        write_reg(REG_IDX_UNMAPPED, 32'd2);
        check_window_reg();
        send_sample(16'sh8000);
        wait_idle();
    endtask

    // Smallest window, and a window above the ring depth
    task automatic test_window_limits();
        write_reg(REG_IDX_WINDOW, 32'd1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_idle();
        write_reg(REG_IDX_WINDOW, 32'd255);
        check_window_reg();
        send_sample(16'sh5555);
        send_sample(-16'sh2AAB);
        wait_idle();
    endtask

    // Random samples in runs, each run under a freshly written window
    task automatic test_random_stream(input int n_items, input int send_pct, input int recv_pct);
        int                    sent;
        int                    run_len;
        int                    w;
        sample_t               s;
        logic [APB_DATA_W-1:0] value;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(7))
                0: w = 1;
                1: w = WINDOW_MAX;
                2: w = $urandom_range(255, WINDOW_MAX + 1);
                3: w = 2;
                default: w = $urandom_range(WINDOW_MAX - 1, 3);
            endcase
            if ($urandom_range(5) == 0) begin
                value = $urandom() & 32'hFFFF_FF00;
                write_reg($urandom_range(1) ? REG_IDX_UNMAPPED : REG_IDX_WINDOW, value);
            end
            value = ($urandom() & 32'hFFFF_FF00) | APB_DATA_W'(w);
            write_reg(REG_IDX_WINDOW, value);
            check_window_reg();
            run_len = window_len + $urandom_range(80, 20);
            while (run_len > 0 && sent < n_items) begin
                s = pick_sample();
                // Hold a value now and then so the average settles on it
                if ($urandom_range(7) == 0) begin
                    repeat ($urandom_range(6, 2)) begin
                        send_sample(s);
                        sent++;
                        run_len--;
                    end
                end else begin
                    send_sample(s);
                    sent++;
                    run_len--;
                end
            end
            wait_idle();
        end
    endtask

    // Receiver side: stall at the rate of the current phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted average with the oldest prediction
    always @(posedge i_clk) begin
        avg_result_t exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_averages.size() == 0) begin
                note_mismatch($sformatf("unexpected result average=%0d full=%0b",
                                        $signed(m_axis_tdata[SAMPLE_BITS-1:0]),
                                        m_axis_tuser[0]));
            end else begin
                exp_r = pending_averages.pop_front();
                results_checked++;
                if (m_axis_tdata[SAMPLE_BITS-1:0] !== exp_r.average) begin
                    note_mismatch($sformatf("average %0d, expected %0d",
                                            $signed(m_axis_tdata[SAMPLE_BITS-1:0]),
                                            exp_r.average));
                end
                if (m_axis_tuser[0] !== exp_r.full) begin
                    note_mismatch($sformatf("window_full %0b, expected %0b",
                                            m_axis_tuser[0], exp_r.full));
                end
            end
        end
    end

    initial begin
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        fail_count      = 0;
        results_checked = 0;
        samples_sent    = 0;
        window_writes   = 0;
        window_len      = WINDOW_RESET;
        window_sum      = 0;
        next_slot       = 0;
        held_count      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_default_window();
        test_truncation();
        test_ignored_writes();
        test_window_limits();
        test_random_stream(600, 15, 74);
        test_random_stream(600, 74, 15);
        test_random_stream(600, 0, 0);

        wait_idle();
        $display("Run covered %0d samples and %0d results under %0d register writes,",
                 samples_sent, results_checked, window_writes);
        $display("with windows from 1 to the ring depth and three idle patterns.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("Timeout with %0d averages outstanding", pending_averages.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/swa_pkg.sv
hdl/swa_ring.sv
hdl/swa_div.sv
hdl/sliding_window_average_core.sv
verif/sliding_window_average_core_test.sv
